@@ hdl/qkcv_pkg.sv @@
// ----------------------------------------------------------------------------
// qkcv_pkg
// Shared types, constants and the transition weight table for the
// quadrature knob with clamped value.
// ----------------------------------------------------------------------------
package qkcv_pkg;

   localparam int ValueWidth = 16;
   localparam int CodeWidth  = 4;
   localparam int StepWidth  = 2;
   localparam int CsrIdxWidth = 2;
   localparam int ReqDataWidth = 8;
   localparam int RspDataWidth = 40;

   typedef logic signed [ValueWidth-1:0] value_type;
   typedef logic signed [StepWidth-1:0]  step_type;
   typedef logic [CodeWidth-1:0]         code_type;
   typedef logic [CsrIdxWidth-1:0]       csr_index_type;

   localparam csr_index_type CsrLowerLimit = 2'd0;
   localparam csr_index_type CsrUpperLimit = 2'd1;
   localparam csr_index_type CsrStartValue = 2'd2;

   localparam value_type LowerDefault = 16'sd0;
   localparam value_type UpperDefault = 16'sd100;
   localparam value_type StartDefault = 16'sd20;
   localparam value_type CountMax     = 16'sd32767;
   localparam value_type CountMin     = -16'sd32767;
   localparam value_type ValueMax     = 16'sh7FFF;
   localparam value_type ValueMin     = 16'sh8000;

   localparam value_type PhaseUp      = 16'sd4;
   localparam value_type PhaseDown    = -16'sd4;
   localparam value_type WeightInvalid = 16'sd14;

   localparam code_type CodeReset = 4'd3;

   localparam step_type StepNone = 2'sb00;
   localparam step_type StepUp   = 2'sb01;
   localparam step_type StepDown = 2'sb11;

   typedef struct packed {
      value_type rotation_count;
      logic      value_changed;
      value_type clamped_value;
      step_type  step;
   } rsp_type;

   function automatic value_type weight_of(code_type code);
      value_type w;
      unique case (code)
         4'd0:    w = 16'sd0;
         4'd1:    w = -16'sd1;
         4'd2:    w = 16'sd1;
         4'd3:    w = WeightInvalid;
         4'd4:    w = 16'sd1;
         4'd5:    w = 16'sd0;
         4'd6:    w = WeightInvalid;
         4'd7:    w = -16'sd1;
         4'd8:    w = -16'sd1;
         4'd9:    w = WeightInvalid;
         4'd10:   w = 16'sd0;
         4'd11:   w = 16'sd1;
         4'd12:   w = WeightInvalid;
         4'd13:   w = 16'sd1;
         4'd14:   w = -16'sd1;
         default: w = 16'sd0;
      endcase
      return w;
   endfunction

endpackage

@@ hdl/qkcv_decode.sv @@
// ----------------------------------------------------------------------------
// qkcv_decode
// Transition code shift register, phase accumulator and detent decision.
// ----------------------------------------------------------------------------
module qkcv_decode (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  logic               pin_a,
   input  logic               pin_b,
   output qkcv_pkg::step_type step
);

   qkcv_pkg::code_type  code_ff, code_in;
   qkcv_pkg::value_type phase_ff, phase_in;
   qkcv_pkg::value_type phase_sum;
   qkcv_pkg::step_type  step_dec;

   always_comb begin
      code_in   = {code_ff[1:0], pin_a, pin_b};
      phase_sum = phase_ff + qkcv_pkg::weight_of(code_in);
      step_dec  = qkcv_pkg::StepNone;
      phase_in  = phase_sum;
      if (phase_sum[1:0] == 2'b00) begin
         phase_in = '0;
         if (phase_sum == qkcv_pkg::PhaseUp) begin
            step_dec = qkcv_pkg::StepDown;
         end else if (phase_sum == qkcv_pkg::PhaseDown) begin
            step_dec = qkcv_pkg::StepUp;
         end
      end
   end

   assign step = enable ? step_dec : qkcv_pkg::StepNone;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff  <= qkcv_pkg::CodeReset;
         phase_ff <= '0;
      end else if (enable) begin
         code_ff  <= code_in;
         phase_ff <= phase_in;
      end
   end

   // phase is cleared whenever it lands on a multiple of four
   assert property (@(posedge clock) disable iff (reset)
      enable && step != qkcv_pkg::StepNone |=> phase_ff == '0)
      else $error("phase not cleared after detent");

endmodule

@@ hdl/quadrature_knob_clamped_value.sv @@
// A req_ transaction is registered before it shows on rsp_. Throughput: one
// transaction per cycle while the skid register is empty; a two-entry output
// stage (output + skid register) keeps req_tready up while one result waits.
// Reset: limits 0 / 100, value 20, count 0, flag 0, transition code 3.
// A csr_ write is always accepted; a start_value write also reloads the value.
// ----------------------------------------------------------------------------
// quadrature_knob_clamped_value
// Rotary encoder decoder driving a saturating count and a clamped value.
// ----------------------------------------------------------------------------
module quadrature_knob_clamped_value (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // pin_event, pin_a, pin_b, ack_value, take_count, 3 zero bits
   input  logic [qkcv_pkg::ReqDataWidth-1:0]     req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // step[1:0], clamped_value[17:2], value_changed[18], rotation_count[34:19]
   output logic [qkcv_pkg::RspDataWidth-1:0]     rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  qkcv_pkg::csr_index_type               csr_index,
   input  logic [qkcv_pkg::ValueWidth-1:0]       csr_data
);

   logic req_fire, rsp_fire, csr_fire;
   logic pin_event, pin_a, pin_b, ack_value, take_count;

   qkcv_pkg::value_type lower_ff, lower_in;
   qkcv_pkg::value_type upper_ff, upper_in;
   qkcv_pkg::value_type knob_ff, knob_in;
   qkcv_pkg::value_type count_ff, count_in;
   logic                changed_ff, changed_in;

   qkcv_pkg::step_type  step;
   qkcv_pkg::value_type step_ext, knob_next, count_next;
   logic                move, moved, changed_now;
   qkcv_pkg::rsp_type   result;

   logic                out_valid_ff, skid_valid_ff;
   qkcv_pkg::rsp_type   out_data_ff, skid_data_ff;

   assign pin_event  = req_tdata[0];
   assign pin_a      = req_tdata[1];
   assign pin_b      = req_tdata[2];
   assign ack_value  = req_tdata[3];
   assign take_count = req_tdata[4];

   assign req_tready = !skid_valid_ff;
   assign csr_ready  = 1'b1;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign csr_fire   = csr_valid && csr_ready;

   qkcv_decode u_decode (
      .clock  (clock),
      .reset  (reset),
      .enable (req_fire && pin_event),
      .pin_a  (pin_a),
      .pin_b  (pin_b),
      .step   (step)
   );

   always_comb begin
      step_ext = {{(qkcv_pkg::ValueWidth-qkcv_pkg::StepWidth){step[1]}}, step};

      count_next = count_ff;
      if (step == qkcv_pkg::StepUp && count_ff != qkcv_pkg::CountMax) begin
         count_next = count_ff + step_ext;
      end else if (step == qkcv_pkg::StepDown && count_ff != qkcv_pkg::CountMin) begin
         count_next = count_ff + step_ext;
      end

      move = (knob_ff > lower_ff && knob_ff < upper_ff) ||
             (knob_ff == upper_ff && step == qkcv_pkg::StepDown) ||
             (knob_ff == lower_ff && step == qkcv_pkg::StepUp);
      moved = move &&
              !(step == qkcv_pkg::StepUp && knob_ff == qkcv_pkg::ValueMax) &&
              !(step == qkcv_pkg::StepDown && knob_ff == qkcv_pkg::ValueMin) &&
              step != qkcv_pkg::StepNone;
      knob_next   = moved ? knob_ff + step_ext : knob_ff;
      changed_now = changed_ff || moved;

      result.step           = step;
      result.clamped_value  = knob_next;
      result.value_changed  = changed_now;
      result.rotation_count = count_next;

      lower_in   = lower_ff;
      upper_in   = upper_ff;
      knob_in    = knob_ff;
      count_in   = count_ff;
      changed_in = changed_ff;

      if (req_fire) begin
         knob_in    = knob_next;
         count_in   = take_count ? '0 : count_next;
         changed_in = ack_value ? 1'b0 : changed_now;
      end

      if (csr_fire) begin
         unique case (csr_index)
            qkcv_pkg::CsrLowerLimit: lower_in = csr_data;
            qkcv_pkg::CsrUpperLimit: upper_in = csr_data;
            qkcv_pkg::CsrStartValue: knob_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff   <= qkcv_pkg::LowerDefault;
         upper_ff   <= qkcv_pkg::UpperDefault;
         knob_ff    <= qkcv_pkg::StartDefault;
         count_ff   <= '0;
         changed_ff <= 1'b0;
      end else begin
         lower_ff   <= lower_in;
         upper_ff   <= upper_in;
         knob_ff    <= knob_in;
         count_ff   <= count_in;
         changed_ff <= changed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_fire) begin
            out_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (req_fire) begin
         if (!out_valid_ff || rsp_fire) begin
            out_data_ff  <= result;
            out_valid_ff <= 1'b1;
         end else begin
            skid_data_ff  <= result;
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_fire) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(qkcv_pkg::RspDataWidth-$bits(qkcv_pkg::rsp_type)){1'b0}},
                        out_data_ff};

   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds data while output register is empty");

   assert property (@(posedge clock) disable iff (reset)
      count_ff != qkcv_pkg::ValueMin)
      else $error("rotation count left its saturation range");

   assert property (@(posedge clock) disable iff (reset)
      !req_fire && !csr_fire |=> $stable(knob_ff) && $stable(count_ff))
      else $error("state moved without a transaction");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> out_data_ff.step != 2'sb10)
      else $error("illegal step code on output");

endmodule

@@ bench/tb_quadrature_knob_clamped_value.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quadrature_knob_clamped_value
// Drives encoder pin samples, acknowledge and take flags and limit settings
// into the knob block with random gaps on both stream sides, predicts every
// readout in a scoreboard, and checks each returned transaction field by field.
// ----------------------------------------------------------------------------
module tb_quadrature_knob_clamped_value;

   localparam int PhaseWeight [16] = '{0, -1, 1, 14, 1, 0, 14, -1,
                                       -1, 14, 0, 1, 14, 1, -1, 0};
   localparam logic [1:0] Gray [4] = '{2'b11, 2'b10, 2'b00, 2'b01};
   localparam qkcv_pkg::csr_index_type CsrUnused = 2'd3;
   localparam int CountSat = 32767;
   localparam int RandomPhases = 8;
   localparam int PhaseItems = 175;
   localparam int SpinDetents = 2;

   class knob_tracker;
      int lower, upper, start, knob, count;
      logic [3:0] code;
      logic [15:0] phase;
      bit changed;
      qkcv_pkg::rsp_type readouts [$];
      int errors;

      function new();
         lower = 0;
         upper = 100;
         start = 20;
         knob = start;
         count = 0;
         code = 4'd3;
         phase = '0;
         changed = 1'b0;
         errors = 0;
      endfunction

      function void write_register(qkcv_pkg::csr_index_type idx, logic [15:0] data);
         case (idx)
            qkcv_pkg::CsrLowerLimit: lower = int'($signed(data));
            qkcv_pkg::CsrUpperLimit: upper = int'($signed(data));
            qkcv_pkg::CsrStartValue: begin
               start = int'($signed(data));
               knob = start;
            end
            default: ;
         endcase
      endfunction

      function void note_pin_sample(logic [7:0] data);
         qkcv_pkg::rsp_type r;
         int dir;
         int nxt;
         bit move;
         dir = 0;
         if (data[0]) begin
            code = {code[1:0], data[1], data[2]};
            phase = phase + 16'(PhaseWeight[code]);
            if (phase[1:0] == 2'b00) begin
               if (phase == 16'd4) dir = -1;
               else if (phase == 16'hFFFC) dir = 1;
               phase = '0;
            end
         end
         if (dir != 0) begin
            count += dir;
            if (count > CountSat) count = CountSat;
            if (count < -CountSat) count = -CountSat;
            move = (knob > lower && knob < upper) || (knob == upper && dir == -1) ||
                   (knob == lower && dir == 1);
            if (move) begin
               nxt = knob + dir;
               if (nxt >= -32768 && nxt <= 32767) begin
                  knob = nxt;
                  changed = 1'b1;
               end
            end
         end
         r.step = qkcv_pkg::step_type'(dir);
         r.clamped_value = qkcv_pkg::value_type'(knob);
         r.value_changed = changed;
         r.rotation_count = qkcv_pkg::value_type'(count);
         readouts.push_back(r);
         if (data[3]) changed = 1'b0;
         if (data[4]) count = 0;
      endfunction

      function void compare(string field, logic signed [15:0] want,
                            logic signed [15:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_readout(logic [qkcv_pkg::RspDataWidth-1:0] data);
         qkcv_pkg::rsp_type got, want;
         got = data[$bits(qkcv_pkg::rsp_type)-1:0];
         if (readouts.size() == 0) begin
            $display("%0t: unexpected transaction expected none actual %h", $time, data);
            errors++;
            return;
         end
         want = readouts.pop_front();
         compare("step", want.step, got.step);
         compare("clamped_value", want.clamped_value, got.clamped_value);
         compare("value_changed", want.value_changed, got.value_changed);
         compare("rotation_count", want.rotation_count, got.rotation_count);
         compare("padding", '0,
                 data[qkcv_pkg::RspDataWidth-1:$bits(qkcv_pkg::rsp_type)]);
      endfunction

      function int pending();
         return readouts.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [qkcv_pkg::ReqDataWidth-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [qkcv_pkg::RspDataWidth-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   qkcv_pkg::csr_index_type csr_index = qkcv_pkg::CsrLowerLimit;
   logic [qkcv_pkg::ValueWidth-1:0] csr_data = '0;

   knob_tracker tracker;
   int pos = 0;
   bit req_gaps = 1'b1;
   bit rsp_gaps = 1'b1;

   always #4 clock = ~clock;

   quadrature_knob_clamped_value u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   function automatic logic [7:0] pack_sample(bit ev, logic [1:0] ab, bit ack, bit take);
      return {3'b000, take, ack, ab[0], ab[1], ev};
   endfunction

   task automatic send_sample(input logic [7:0] data);
      int gap;
      gap = req_gaps ? $urandom_range(0, 10) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data;
      do @(posedge clock); while (!req_tready);
      tracker.note_pin_sample(data);
   endtask

   task automatic turn(input int dir, input bit ack, input bit take);
      pos = (pos + dir + 4) % 4;
      send_sample(pack_sample(1'b1, Gray[pos], ack, take));
   endtask

   task automatic jump(input logic [1:0] ab, input bit ack, input bit take);
      for (int i = 0; i < 4; i++)
         if (Gray[i] == ab) pos = i;
      send_sample(pack_sample(1'b1, ab, ack, take));
   endtask

   task automatic write_csr(input qkcv_pkg::csr_index_type idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      tracker.write_register(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // result side: random stalls, check every accepted transaction
   initial begin : rsp_side
      int gap;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         gap = rsp_gaps ? $urandom_range(0, 10) : 0;
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         tracker.check_readout(rsp_tdata);
      end
   end

   initial begin : stimulus
      int pick, run_left, dir;
      bit ack, take;
      tracker = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: idle samples, full detents both ways, flags, bad transitions
      send_sample(pack_sample(1'b0, 2'b10, 1'b0, 1'b0));
      send_sample(pack_sample(1'b0, 2'b01, 1'b0, 1'b0));
      repeat (4) turn(1, 1'b0, 1'b0);
      send_sample(pack_sample(1'b0, 2'b11, 1'b1, 1'b1));
      repeat (4) turn(-1, 1'b0, 1'b0);
      jump(2'b00, 1'b0, 1'b0);
      jump(2'b11, 1'b0, 1'b0);
      jump(2'b11, 1'b0, 1'b0);
      repeat (2) turn(1, 1'b0, 1'b0);
      repeat (2) turn(-1, 1'b0, 1'b0);
      jump(2'b00, 1'b0, 1'b0);
      jump(2'b10, 1'b0, 1'b0);
      repeat (4) turn(-1, 1'b1, 1'b0);
      send_sample(pack_sample(1'b0, 2'b00, 1'b0, 1'b1));
      send_sample(pack_sample(1'b0, 2'b11, 1'b1, 1'b0));
      wait_drained();

      run_left = 0;
      dir = 1;
      for (int ph = 0; ph < RandomPhases; ph++) begin
         req_gaps = ($urandom_range(0, 3) != 0);
         rsp_gaps = ($urandom_range(0, 3) != 0);
         case (ph)
            0: begin
               write_csr(qkcv_pkg::CsrStartValue, 16'(0));
               write_csr(qkcv_pkg::CsrLowerLimit, 16'(-3));
               write_csr(qkcv_pkg::CsrUpperLimit, 16'(4));
            end
            1: begin
               write_csr(qkcv_pkg::CsrLowerLimit, 16'h8000);
               write_csr(qkcv_pkg::CsrUpperLimit, 16'h7FFF);
               write_csr(qkcv_pkg::CsrStartValue, 16'($urandom));
            end
            2: begin
               write_csr(qkcv_pkg::CsrLowerLimit, 16'h7FFF);
               write_csr(qkcv_pkg::CsrUpperLimit, 16'h7FFF);
               write_csr(qkcv_pkg::CsrStartValue, 16'h7FFF);
            end
            3: begin
               write_csr(qkcv_pkg::CsrLowerLimit, 16'h8000);
               write_csr(qkcv_pkg::CsrUpperLimit, 16'h8000);
               write_csr(qkcv_pkg::CsrStartValue, 16'h8000);
            end
            4: begin
               write_csr(qkcv_pkg::CsrStartValue, 16'(50));
               write_csr(qkcv_pkg::CsrLowerLimit, 16'(10));
               write_csr(qkcv_pkg::CsrUpperLimit, 16'(20));
               write_csr(CsrUnused, 16'($urandom));
            end
            5: begin
               write_csr(qkcv_pkg::CsrLowerLimit, 16'(100));
               write_csr(qkcv_pkg::CsrUpperLimit, 16'(-100));
               write_csr(qkcv_pkg::CsrStartValue, 16'(100));
            end
            6: begin
               write_csr(qkcv_pkg::CsrLowerLimit, 16'($urandom));
               write_csr(qkcv_pkg::CsrUpperLimit, 16'($urandom));
               write_csr(qkcv_pkg::CsrStartValue, 16'($urandom));
               write_csr(CsrUnused, 16'($urandom));
            end
            default: begin
               write_csr(qkcv_pkg::CsrLowerLimit, 16'(0));
               write_csr(qkcv_pkg::CsrUpperLimit, 16'(100));
               write_csr(qkcv_pkg::CsrStartValue, 16'(20));
            end
         endcase
         for (int n = 0; n < PhaseItems; n++) begin
            if (run_left == 0) begin
               dir = $urandom_range(0, 1) ? 1 : -1;
               run_left = $urandom_range(4, 48);
            end
            pick = $urandom_range(0, 99);
            ack = ($urandom_range(0, 3) == 0);
            take = ($urandom_range(0, 7) == 0);
            if (pick < 80) begin
               turn(dir, ack, take);
               run_left--;
            end else if (pick < 90) begin
               send_sample(pack_sample(1'b0, 2'($urandom), ack, take));
            end else begin
               jump(2'($urandom), ack, take);
            end
         end
         wait_drained();
      end

      // gapless back-to-back spins each way
      req_gaps = 1'b0;
      rsp_gaps = 1'b0;
      send_sample(pack_sample(1'b0, 2'b00, 1'b1, 1'b1));
      repeat (4 * SpinDetents) turn(1, 1'b0, 1'b0);
      send_sample(pack_sample(1'b0, 2'b00, 1'b0, 1'b1));
      repeat (4 * SpinDetents) turn(-1, 1'b0, 1'b0);
      send_sample(pack_sample(1'b0, 2'b00, 1'b1, 1'b1));
      wait_drained();

      if (tracker.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin : watchdog
      #15_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
